@@ rtl/mme_pkg.sv @@
`timescale 1ns / 1ps

package mme_pkg;

  localparam int MAX_DIM_DEF = 8;

  localparam int DIM_W  = 4;   // width of a dimension register
  localparam int IDX_W  = 3;   // width of a row or column field
  localparam int ELEM_W = 16;  // Q8.8 element
  localparam int PROD_W = 32;  // Q16.16 product of two elements
  localparam int VAL_W  = 32;  // saturated result value
  localparam int ACC_W  = 36;  // up to 16 products summed without loss

  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  localparam logic [1:0] STATUS_PROD  = 2'd0;
  localparam logic [1:0] STATUS_EWISE = 2'd1;
  localparam logic [1:0] STATUS_ERR   = 2'd2;

  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_COLS_A = 2'd1;
  localparam logic [1:0] REG_ROWS_B = 2'd2;
  localparam logic [1:0] REG_COLS_B = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load_a;
    logic             load_b;
    logic             rd_en;
    logic             rd_first;
    logic             load_out;
    logic             out_err;
    logic             out_last;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic [1:0]       out_status;
  } mme_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } mme_stat_t;

endpackage

@@ rtl/mme_ctrl.sv @@
`timescale 1ns / 1ps

module mme_ctrl #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF,
  parameter int AW      = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               req_type_i,
  input  logic [mme_pkg::IDX_W-1:0] row_i,
  input  logic [mme_pkg::IDX_W-1:0] col_i,
  input  logic [mme_pkg::DIM_W-1:0] rows_a_i,
  input  logic [mme_pkg::DIM_W-1:0] cols_a_i,
  input  logic [mme_pkg::DIM_W-1:0] rows_b_i,
  input  logic [mme_pkg::DIM_W-1:0] cols_b_i,
  input  mme_pkg::mme_stat_t       stat_i,
  output mme_pkg::mme_cmd_t        cmd_o,
  output logic [AW-1:0]            rd_addr_a_o,
  output logic [AW-1:0]            rd_addr_b_o
);
  import mme_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_ERR   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [DIM_W-1:0] i_q, i_d, j_q, j_d, t_q, t_d;
  logic             prod_q, prod_d;

  logic [DIM_W-1:0] na, ma, nb, mb;
  logic [DIM_W-1:0] n_terms, n_rows, n_cols, a_col, b_row;
  logic             accept, in_range, is_last;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (int'(v) > MAX_DIM) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  always_comb begin
    na = eff_dim(rows_a_i);
    ma = eff_dim(cols_a_i);
    nb = eff_dim(rows_b_i);
    mb = eff_dim(cols_b_i);
    n_terms = prod_q ? ma : DIM_W'(1);
    n_rows  = na;
    n_cols  = prod_q ? mb : ma;
    a_col   = prod_q ? t_q : j_q;
    b_row   = prod_q ? t_q : i_q;
    is_last = (i_q == n_rows - DIM_W'(1)) && (j_q == n_cols - DIM_W'(1));
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign in_range    = (int'(row_i) < MAX_DIM) && (int'(col_i) < MAX_DIM);
  assign rd_addr_a_o = AW'(int'(i_q) * MAX_DIM + int'(a_col));
  assign rd_addr_b_o = AW'(int'(b_row) * MAX_DIM + int'(j_q));

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    t_d     = t_q;
    prod_d  = prod_q;
    cmd_o   = '0;
    cmd_o.out_row    = i_q[IDX_W-1:0];
    cmd_o.out_col    = j_q[IDX_W-1:0];
    cmd_o.out_status = prod_q ? STATUS_PROD : STATUS_EWISE;
    cmd_o.out_last   = is_last;
    cmd_o.rd_first   = (t_q == '0);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_a = (req_type_i == REQ_LOAD_A) && in_range;
          cmd_o.load_b = (req_type_i == REQ_LOAD_B) && in_range;
          if (req_type_i == REQ_START) begin
            i_d = '0;
            j_d = '0;
            t_d = '0;
            if (ma == nb) begin
              prod_d  = 1'b1;
              state_d = ST_MAC;
            end else if (na == nb && ma == mb) begin
              prod_d  = 1'b0;
              state_d = ST_MAC;
            end else begin
              state_d = ST_ERR;
            end
          end
        end
      end
      ST_MAC: begin
        // issue one pair of reads per term
        cmd_o.rd_en = 1'b1;
        if (t_q == n_terms - DIM_W'(1)) begin
          t_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          t_d = t_q + DIM_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy && stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_MAC;
            if (j_q == n_cols - DIM_W'(1)) begin
              j_d = '0;
              i_d = i_q + DIM_W'(1);
            end else begin
              j_d = j_q + DIM_W'(1);
            end
          end
        end
      end
      ST_ERR: begin
        cmd_o.out_row    = '0;
        cmd_o.out_col    = '0;
        cmd_o.out_status = STATUS_ERR;
        cmd_o.out_last   = 1'b1;
        cmd_o.out_err    = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      t_q     <= '0;
      prod_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      t_q     <= t_d;
      prod_q  <= prod_d;
    end
  end

endmodule

@@ rtl/mme_datapath.sv @@
`timescale 1ns / 1ps

module mme_datapath #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF,
  parameter int AW      = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mme_pkg::mme_cmd_t                cmd_i,
  output mme_pkg::mme_stat_t               stat_o,
  input  logic [mme_pkg::IDX_W-1:0]        row_i,
  input  logic [mme_pkg::IDX_W-1:0]        col_i,
  input  logic signed [mme_pkg::ELEM_W-1:0] element_i,
  input  logic [AW-1:0]                    rd_addr_a_i,
  input  logic [AW-1:0]                    rd_addr_b_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [mme_pkg::VAL_W-1:0] out_value_o,
  output logic [mme_pkg::IDX_W-1:0]        out_row_o,
  output logic [mme_pkg::IDX_W-1:0]        out_col_o,
  output logic                             out_last_o,
  output logic [1:0]                       out_status_o,
  output logic                             out_sat_o
);
  import mme_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic signed [ELEM_W-1:0] mem_a [DEPTH];
  logic signed [ELEM_W-1:0] mem_b [DEPTH];

  logic [AW-1:0]            wr_addr;
  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q;
  logic                     rd_valid_q, rd_first_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     mul_valid_q, mul_first_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     out_valid_q;
  logic signed [VAL_W-1:0]  value_q, sat_value;
  logic [IDX_W-1:0]         row_q, col_q;
  logic                     last_q, sat_q, ovf_pos, ovf_neg;
  logic [1:0]               status_q;

  assign wr_addr = AW'(int'(row_i) * MAX_DIM + int'(col_i));

  // stores: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) mem_a[wr_addr] <= element_i;
    if (cmd_i.load_b) mem_b[wr_addr] <= element_i;
    if (cmd_i.rd_en) begin
      a_rd_q <= mem_a[rd_addr_a_i];
      b_rd_q <= mem_b[rd_addr_b_i];
    end
    if (rd_valid_q) prod_q <= PROD_W'(a_rd_q * b_rd_q);
    if (mul_valid_q) acc_q <= acc_d;
  end

  always_comb begin
    acc_d = (mul_first_q ? ACC_W'(0) : acc_q) + ACC_W'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      rd_first_q  <= 1'b0;
      mul_valid_q <= 1'b0;
      mul_first_q <= 1'b0;
    end else begin
      rd_valid_q  <= cmd_i.rd_en;
      rd_first_q  <= cmd_i.rd_first;
      mul_valid_q <= rd_valid_q;
      mul_first_q <= rd_first_q;
    end
  end

  // clip when the bits above the result's sign disagree with it
  always_comb begin
    ovf_pos = !acc_q[ACC_W-1] && (acc_q[ACC_W-2:VAL_W-1] != '0);
    ovf_neg =  acc_q[ACC_W-1] && (acc_q[ACC_W-2:VAL_W-1] != '1);
    if (ovf_pos) sat_value = {1'b0, {(VAL_W-1){1'b1}}};
    else if (ovf_neg) sat_value = {1'b1, {(VAL_W-1){1'b0}}};
    else sat_value = acc_q[VAL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      value_q  <= cmd_i.out_err ? '0 : sat_value;
      sat_q    <= cmd_i.out_err ? 1'b0 : (ovf_pos || ovf_neg);
      row_q    <= cmd_i.out_row;
      col_q    <= cmd_i.out_col;
      last_q   <= cmd_i.out_last;
      status_q <= cmd_i.out_status;
    end
  end

  assign stat_o.pipe_busy = rd_valid_q || mul_valid_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = value_q;
  assign out_row_o    = row_q;
  assign out_col_o    = col_q;
  assign out_last_o   = last_q;
  assign out_status_o = status_q;
  assign out_sat_o    = sat_q;

endmodule

@@ rtl/matrix_multiply_engine_unit.sv @@
`timescale 1ns / 1ps

// Matrix multiply engine.
// Slave stream: tuser carries the request kind (load A, load B, start); tdata
// carries row, column and a signed Q8.8 element. Loads write one element of
// store A or B each and give no result; loads outside the store
// and unknown kinds are dropped.
// A start multiplies the stored matrices using the shape registers on the APB
// port: ordinary product when cols_a equals rows_b, else element-wise product
// for equal shapes, else one error result with status 2.
// Master stream: tdata carries the saturated Q16.16 value, row and column;
// tuser carries status and the clip flag; tlast marks the final result.
// Each result sums K terms, K being cols_a for a product and 1 for the
// element-wise case: one term per cycle through the single read port of each
// store and one multiply-accumulate unit, plus read, multiply and unload
// stages. No request is accepted while a start is at work; the last result
// sits in the output register while loads for the next run are accepted.
// A stalled receiver holds the output register and stalls the walk.
// Reset clears the control state and sets all shapes to 1; store contents are
// undefined until written.

module matrix_multiply_engine_unit #(
  parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // row_index[2:0], col_index[5:3], element[21:6]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // result_value[31:0], result_row[34:32], result_col[37:35]
  output logic [2:0]  m_axis_tuser,   // status[1:0], saturated[2]
  output logic        m_axis_tlast,   // last_result
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mme_pkg::*;

  // store address width, at least one bit
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  logic [DIM_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [DIM_W-1:0] rd_reg;
  logic             cfg_wr;

  mme_cmd_t  cmd;
  mme_stat_t stat;
  logic [AW-1:0] rd_addr_a, rd_addr_b;

  logic signed [VAL_W-1:0] out_value;
  logic [IDX_W-1:0]        out_row, out_col;

  // configuration registers, written in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= DIM_W'(1);
      cols_a_q <= DIM_W'(1);
      rows_b_q <= DIM_W'(1);
      cols_b_q <= DIM_W'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ROWS_A: rows_a_q <= pwdata[DIM_W-1:0];
        REG_COLS_A: cols_a_q <= pwdata[DIM_W-1:0];
        REG_ROWS_B: rows_b_q <= pwdata[DIM_W-1:0];
        REG_COLS_B: cols_b_q <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS_A: rd_reg = rows_a_q;
      REG_COLS_A: rd_reg = cols_a_q;
      REG_ROWS_B: rd_reg = rows_b_q;
      REG_COLS_B: rd_reg = cols_b_q;
      default:    rd_reg = '0;
    endcase
  end

  assign prdata = {{(32-DIM_W){1'b0}}, rd_reg};

  mme_ctrl #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .row_i       (s_axis_tdata[2:0]),
    .col_i       (s_axis_tdata[5:3]),
    .rows_a_i    (rows_a_q),
    .cols_a_i    (cols_a_q),
    .rows_b_i    (rows_b_q),
    .cols_b_i    (cols_b_q),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b)
  );

  mme_datapath #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .row_i        (s_axis_tdata[2:0]),
    .col_i        (s_axis_tdata[5:3]),
    .element_i    (s_axis_tdata[21:6]),
    .rd_addr_a_i  (rd_addr_a),
    .rd_addr_b_i  (rd_addr_b),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (out_value),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .out_last_o   (m_axis_tlast),
    .out_status_o (m_axis_tuser[1:0]),
    .out_sat_o    (m_axis_tuser[2])
  );

  // pack the result and zero-fill to whole bytes
  assign m_axis_tdata = {2'b00, out_col, out_row, out_value};

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import mme_pkg::*;

  localparam int DIM           = MAX_DIM_DEF;
  localparam int CELLS         = DIM * DIM;
  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 9;
  localparam int ITEM_TARGET   = 500;
  localparam int SETTLE_CYCLES = 32;      // pause that lets the pipe settle after the last result
  localparam int HOLD_CYCLES   = 600;     // long receiver hold-off for the pressure test
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SHOW_LIMIT    = 10;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;  // no such request kind; the block drops it

  localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam logic [ELEM_W-1:0] ELEM_MAX = ~ELEM_MIN;
  localparam longint VAL_MAX = (longint'(1) <<< (VAL_W - 1)) - 1;
  localparam longint VAL_MIN = -(longint'(1) <<< (VAL_W - 1));

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
    logic [1:0]       status;
    logic             sat;
  } mme_result_t;

  // Receiver stall styles
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PATTERN, RX_SLOW} rx_style_e;

  // Operand styles: plain random mix, or peaks that push a sum past 32 bits
  typedef enum logic [1:0] {OPS_PLAIN, OPS_POS_PEAK, OPS_NEG_PEAK} operand_style_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // row_index[2:0], col_index[5:3], element[21:6]
  logic [1:0]  s_axis_tuser  = '0;  // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // result_value[31:0], result_row[34:32], result_col[37:35]
  logic [2:0]  m_axis_tuser;        // status[1:0], saturated[2]
  logic        m_axis_tlast;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the stores, the shape registers and the pending results
  logic signed [ELEM_W-1:0] mat_a [CELLS];
  logic signed [ELEM_W-1:0] mat_b [CELLS];
  bit                       a_loaded [CELLS];
  bit                       b_loaded [CELLS];
  logic [DIM_W-1:0]         shape_reg [4];
  mme_result_t              pending_results [$];

  int n_items      = 0;
  int n_results    = 0;
  int n_sat        = 0;
  int n_mismatch   = 0;
  int n_prod_runs  = 0;
  int n_ewise_runs = 0;
  int n_err_runs   = 0;
  int cycle_count  = 0;

  bit          tx_live       = 1'b0;
  int unsigned tx_burst_left = 0;

  int        hold_req   = 0;
  int        hold_seen  = 0;
  int        hold_left  = 0;
  rx_style_e rx_style   = RX_FREE;
  int        rx_span    = 0;
  logic [7:0] rx_pattern = 8'hA5;

  mme_result_t seen_result;
  mme_result_t want_result;

  matrix_multiply_engine_unit #(
    .MAX_DIM(DIM)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_results.size());
      $display("matrix_multiply_engine_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp a raw shape register the way the block reads it: 0 acts as 1,
  // anything above the store size acts as the store size.
  function automatic int unsigned eff_dim(logic [DIM_W-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > DIM) return DIM;
    return int'(raw);
  endfunction

  function automatic logic [1:0] run_kind(int unsigned na, int unsigned ma,
                                          int unsigned nb, int unsigned mb);
    if (ma == nb) return STATUS_PROD;
    if (na == nb && ma == mb) return STATUS_EWISE;
    return STATUS_ERR;
  endfunction

  // Saturate one exact sum to Q16.16 and queue it
  function automatic void queue_result(longint acc, int unsigned r, int unsigned c, bit last,
                                       logic [1:0] status);
    mme_result_t res;
    res.sat = 1'b0;
    if (acc > VAL_MAX) begin
      acc = VAL_MAX;
      res.sat = 1'b1;
    end else if (acc < VAL_MIN) begin
      acc = VAL_MIN;
      res.sat = 1'b1;
    end
    res.value  = acc[VAL_W-1:0];
    res.row    = IDX_W'(r);
    res.col    = IDX_W'(c);
    res.last   = last;
    res.status = status;
    pending_results = {pending_results, res};
  endfunction

  // Work out every result of a start from the current stores and shapes
  function automatic void predict_start();
    int unsigned na, ma, nb, mb;
    longint      acc;
    logic [1:0]  kind;
    na   = eff_dim(shape_reg[REG_ROWS_A]);
    ma   = eff_dim(shape_reg[REG_COLS_A]);
    nb   = eff_dim(shape_reg[REG_ROWS_B]);
    mb   = eff_dim(shape_reg[REG_COLS_B]);
    kind = run_kind(na, ma, nb, mb);
    case (kind)
      STATUS_PROD: begin
        n_prod_runs++;
        for (int unsigned i = 0; i < na; i++) begin
          for (int unsigned j = 0; j < mb; j++) begin
            acc = 0;
            for (int unsigned t = 0; t < ma; t++) begin
              acc += longint'(mat_a[i*DIM + t]) * longint'(mat_b[t*DIM + j]);
            end
            queue_result(acc, i, j, (i == na - 1) && (j == mb - 1), STATUS_PROD);
          end
        end
      end
      STATUS_EWISE: begin
        n_ewise_runs++;
        for (int unsigned i = 0; i < na; i++) begin
          for (int unsigned j = 0; j < ma; j++) begin
            acc = longint'(mat_a[i*DIM + j]) * longint'(mat_b[i*DIM + j]);
            queue_result(acc, i, j, (i == na - 1) && (j == ma - 1), STATUS_EWISE);
          end
        end
      end
      default: begin
        n_err_runs++;
        queue_result(0, 0, 0, 1'b1, STATUS_ERR);
      end
    endcase
  endfunction

  // Update the predictor for a request the block just took
  function automatic void apply_request(logic [1:0] kind, logic [IDX_W-1:0] row,
                                        logic [IDX_W-1:0] col, logic [ELEM_W-1:0] elem);
    int unsigned addr;
    addr = int'(row) * DIM + int'(col);
    case (kind)
      REQ_LOAD_A: begin
        mat_a[addr]    = elem;
        a_loaded[addr] = 1'b1;
        n_items++;
      end
      REQ_LOAD_B: begin
        mat_b[addr]    = elem;
        b_loaded[addr] = 1'b1;
        n_items++;
      end
      REQ_START: begin
        predict_start();
        n_items++;
      end
      default: ;
    endcase
  endfunction

  // List the store entries a run reads: A entries as addr, B entries as CELLS + addr
  function automatic void list_operands(logic [1:0] kind, int unsigned na, int unsigned ma,
                                        int unsigned nb, int unsigned mb,
                                        ref int unsigned plan[$]);
    plan.delete();
    if (kind == STATUS_PROD) begin
      for (int unsigned i = 0; i < na; i++)
        for (int unsigned t = 0; t < ma; t++) plan = {plan, i*DIM + t};
      for (int unsigned t = 0; t < nb; t++)
        for (int unsigned j = 0; j < mb; j++) plan = {plan, CELLS + t*DIM + j};
    end else if (kind == STATUS_EWISE) begin
      for (int unsigned i = 0; i < na; i++) begin
        for (int unsigned j = 0; j < ma; j++) begin
          plan = {plan, i*DIM + j};
          plan = {plan, CELLS + i*DIM + j};
        end
      end
    end
  endfunction

  function automatic bit operands_ready(logic [1:0] kind, int unsigned na, int unsigned ma,
                                        int unsigned nb, int unsigned mb);
    int unsigned plan[$];
    list_operands(kind, na, ma, nb, mb, plan);
    foreach (plan[p]) begin
      if (plan[p] >= CELLS ? !b_loaded[plan[p] - CELLS] : !a_loaded[plan[p]]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void flag_mismatch(string msg);
    n_mismatch++;
    if (n_mismatch <= SHOW_LIMIT) $display("MISMATCH: %s", msg);
  endfunction

  function automatic string describe(mme_result_t r);
    return $sformatf("value %0d row %0d col %0d last %0d status %0d sat %0d",
                     $signed(r.value), r.row, r.col, r.last, r.status, r.sat);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_result.value  = m_axis_tdata[31:0];
      seen_result.row    = m_axis_tdata[34:32];
      seen_result.col    = m_axis_tdata[37:35];
      seen_result.last   = m_axis_tlast;
      seen_result.status = m_axis_tuser[1:0];
      seen_result.sat    = m_axis_tuser[2];
      n_results++;
      if (seen_result.sat) n_sat++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: %s", describe(seen_result)));
      end else begin
        want_result = pending_results.pop_front();
        if (seen_result.value !== want_result.value || seen_result.row !== want_result.row ||
            seen_result.col !== want_result.col || seen_result.last !== want_result.last ||
            seen_result.status !== want_result.status || seen_result.sat !== want_result.sat)
        begin
          flag_mismatch($sformatf("expected %s, got %s", describe(want_result),
                                  describe(seen_result)));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall in a randomly picked style, repicked when its span runs out;
  // a hold-off request from a test holds tready low until its hold count runs out.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_span    <= $urandom_range(8, 120);
        rx_style   <= rx_style_e'($urandom_range(0, 3));
        rx_pattern <= 8'($urandom);
      end else begin
        rx_span <= rx_span - 1;
      end
      case (rx_style)
        RX_FREE:    m_axis_tready <= 1'b1;
        RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
        RX_PATTERN: begin
          m_axis_tready <= rx_pattern[0];
          // rotate only when the pattern is not being reloaded this cycle
          if (rx_span != 0) rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
        end
        default:    m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request stream and APB drivers
  // ---------------------------------------------------------------------------

  // Send one request; often idle between bursts of random length
  task automatic push_request(input logic [1:0] kind, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col, input logic [ELEM_W-1:0] elem);
    int unsigned gap;
    gap = 0;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    tx_burst_left--;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, elem, col, row};
    tx_live = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_request(kind, row, col, elem);
  endtask

  // Drop valid after the last request of a stretch
  task automatic sender_idle();
    if (tx_live) begin
      s_axis_tvalid <= 1'b0;
      tx_live = 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Pause until every pending result has come, then let the pipe settle
  task automatic wait_drained();
    sender_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [DIM_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {(32 - DIM_W)'($urandom), value};  // upper bits are not stored
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shape_reg[idx] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(shape_reg[idx])) begin
      flag_mismatch($sformatf("register %0d read %0h, expected %0h", idx, prdata,
                              shape_reg[idx]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_shapes();
    apb_read_check(REG_ROWS_A);
    apb_read_check(REG_COLS_A);
    apb_read_check(REG_ROWS_B);
    apb_read_check(REG_COLS_B);
  endtask

  // Write all four shape registers with the block idle, then read them back
  task automatic set_shapes(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ca,
                            input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
    wait_drained();
    apb_write(REG_ROWS_A, ra);
    apb_write(REG_COLS_A, ca);
    apb_write(REG_ROWS_B, rb);
    apb_write(REG_COLS_B, cb);
    read_shapes();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [DIM_W-1:0] encode_dim(int unsigned d);
    if (d == 1 && $urandom_range(0, 3) == 0) return '0;
    if (d == DIM && $urandom_range(0, 1) == 0)
      return DIM_W'($urandom_range(DIM + 1, (1 << DIM_W) - 1));
    return DIM_W'(d);
  endfunction

  function automatic logic [ELEM_W-1:0] pick_element(operand_style_e style, bit for_a);
    case (style)
      OPS_POS_PEAK: return ELEM_MIN;
      OPS_NEG_PEAK: return for_a ? ELEM_MIN : ELEM_MAX;
      default: begin
        case ($urandom_range(0, 7))
          0:       return ELEM_MIN;
          1:       return ELEM_MAX;
          2:       return ELEM_W'($urandom_range(0, 511) - 256);
          3:       return '0;
          default: return ELEM_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // Stray traffic: an unknown request kind or a load of some random entry
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: push_request(REQ_UNKNOWN, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
      1: push_request(REQ_LOAD_A, IDX_W'($urandom), IDX_W'($urandom),
                      pick_element(OPS_PLAIN, 1'b1));
      default: push_request(REQ_LOAD_B, IDX_W'($urandom), IDX_W'($urandom),
                            pick_element(OPS_PLAIN, 1'b0));
    endcase
  endtask

  task automatic start_run();
    push_request(REQ_START, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
  endtask

  // Load every entry a run reads, in shuffled order, with stray traffic mixed in for plain runs
  task automatic load_operands(input logic [1:0] kind, input int unsigned na,
                               input int unsigned ma, input int unsigned nb,
                               input int unsigned mb, input operand_style_e style);
    int unsigned plan[$];
    int unsigned slot, tmp, addr;
    bit          is_b;
    list_operands(kind, na, ma, nb, mb, plan);
    for (int unsigned k = plan.size(); k > 1; k--) begin
      slot          = $urandom_range(0, k - 1);
      tmp           = plan[k-1];
      plan[k-1]     = plan[slot];
      plan[slot]    = tmp;
    end
    foreach (plan[p]) begin
      // keep peak runs clean so every product has the same sign
      if (style == OPS_PLAIN && $urandom_range(0, 11) == 0) send_noise();
      is_b = plan[p] >= CELLS;
      addr = is_b ? plan[p] - CELLS : plan[p];
      push_request(is_b ? REQ_LOAD_B : REQ_LOAD_A, IDX_W'(addr / DIM), IDX_W'(addr % DIM),
                   pick_element(style, !is_b));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Shapes come out of reset as 1x1; walk the 1x1 product through the
  // element extremes, including the largest positive product.
  task automatic test_reset_shape();
    read_shapes();
    push_request(REQ_LOAD_A, '0, '0, ELEM_MAX);
    push_request(REQ_LOAD_B, '0, '0, ELEM_MAX);
    start_run();
    push_request(REQ_LOAD_B, '0, '0, ELEM_MIN);
    start_run();
    push_request(REQ_LOAD_A, '0, '0, ELEM_MIN);
    start_run();
  endtask

  // 1x2 by 1x2: inner sizes differ but shapes match, so element-wise
  task automatic test_elementwise();
    set_shapes(DIM_W'(1), DIM_W'(2), DIM_W'(1), DIM_W'(2));
    push_request(REQ_LOAD_A, '0, IDX_W'(1), ELEM_MAX);
    push_request(REQ_LOAD_B, '0, IDX_W'(1), ELEM_MIN);
    start_run();
  endtask

  // 2x3 by 2x2: neither rule applies, expect the single error result
  task automatic test_dim_error();
    set_shapes(DIM_W'(2), DIM_W'(3), DIM_W'(2), DIM_W'(2));
    start_run();
  endtask

  // Zero shape registers act as 1, giving a 1x3 by 3x1 product; peak operands
  // drive the sum past both ends of the 32-bit range.
  task automatic test_clamped_shape();
    set_shapes('0, DIM_W'(3), DIM_W'(3), '0);
    for (int t = 0; t < 3; t++) begin
      push_request(REQ_LOAD_A, '0, IDX_W'(t), ELEM_MIN);
      push_request(REQ_LOAD_B, IDX_W'(t), '0, ELEM_MIN);
    end
    start_run();
    for (int t = 0; t < 3; t++) push_request(REQ_LOAD_B, IDX_W'(t), '0, ELEM_MAX);
    start_run();
  endtask

  // Unknown request kinds must leave the stores alone and give nothing
  task automatic test_ignored_kind();
    push_request(REQ_UNKNOWN, '0, '0, ELEM_MAX);
    push_request(REQ_UNKNOWN, IDX_W'(DIM - 1), IDX_W'(DIM - 1), ELEM_MIN);
    start_run();
  endtask

  // Full 8x8 product while the receiver holds off: the walk stalls, the
  // block stops taking requests, and the queued loads wait behind it.
  task automatic test_full_size_backpressure();
    set_shapes(DIM_W'(DIM), DIM_W'((1 << DIM_W) - 1), DIM_W'(DIM + 1), DIM_W'(DIM));
    load_operands(STATUS_PROD, DIM, DIM, DIM, DIM, OPS_PLAIN);
    hold_req <= hold_req + 1;
    start_run();
    repeat (8) push_request($urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A, IDX_W'($urandom),
                            IDX_W'($urandom), pick_element(OPS_PLAIN, 1'b1));
    wait_drained();
  endtask

  // Random runs: mostly small well-formed load-then-start sequences, a few up to full
  // size, some error shapes, some reruns on old data, repeated starts and stray traffic.
  task automatic test_random_runs();
    int unsigned    na, ma, nb, mb, pick, lim;
    logic [1:0]     kind;
    operand_style_e style;
    while (n_items < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        // keep the current shapes
        na   = eff_dim(shape_reg[REG_ROWS_A]);
        ma   = eff_dim(shape_reg[REG_COLS_A]);
        nb   = eff_dim(shape_reg[REG_ROWS_B]);
        mb   = eff_dim(shape_reg[REG_COLS_B]);
        kind = run_kind(na, ma, nb, mb);
      end else begin
        pick = $urandom_range(0, 19);
        kind = (pick < 12) ? STATUS_PROD : (pick < 17) ? STATUS_EWISE : STATUS_ERR;
        lim  = ($urandom_range(0, 24) == 0) ? DIM : 3;
        do begin
          na = $urandom_range(1, lim);
          ma = $urandom_range(1, lim);
          nb = $urandom_range(1, lim);
          mb = $urandom_range(1, lim);
          if (kind == STATUS_PROD) begin
            nb = ma;
          end else if (kind == STATUS_EWISE) begin
            nb = na;
            mb = ma;
          end
        end while (run_kind(na, ma, nb, mb) != kind);
        set_shapes(encode_dim(na), encode_dim(ma), encode_dim(nb), encode_dim(mb));
      end
      style = OPS_PLAIN;
      if (kind == STATUS_PROD && $urandom_range(0, 5) == 0)
        style = $urandom_range(0, 1) ? OPS_POS_PEAK : OPS_NEG_PEAK;
      if (kind == STATUS_ERR) begin
        repeat ($urandom_range(0, 3)) send_noise();
      end else if (!($urandom_range(0, 7) == 0 && operands_ready(kind, na, ma, nb, mb))) begin
        load_operands(kind, na, ma, nb, mb, style);
      end
      start_run();
      if ($urandom_range(0, 9) == 0) start_run();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (shape_reg[r]) shape_reg[r] = DIM_W'(1);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_shape();
    test_elementwise();
    test_dim_error();
    test_clamped_shape();
    test_ignored_kind();
    test_full_size_backpressure();
    test_random_runs();
    wait_drained();

    $display("Covered %0d requests over %0d product, %0d element-wise and %0d error runs.",
             n_items, n_prod_runs, n_ewise_runs, n_err_runs);
    $display("Checked %0d results, %0d of them clipped; %0d mismatches.", n_results, n_sat,
             n_mismatch);
    if (n_mismatch == 0) begin
      $display("matrix_multiply_engine_unit: match");
    end else begin
      $display("matrix_multiply_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
